@@ hw/rtl/pss_pkg.sv @@
// Shared types and constants of the preemptive priority scheduler.
`default_nettype none

package pss_pkg;

   // Operation codes carried by the opcode field of an input item.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Saturation value of the tick counter.
   localparam logic [23:0] TICK_MAX = 24'hFF_FFFF;

   // One input item.
   typedef struct packed {
      logic        opcode;
      logic [4:0]  task_index;
      logic [15:0] arrival_time;
      logic [15:0] burst_length;
      logic [7:0]  priority_level;
   } req_type;

   // One result item.
   typedef struct packed {
      logic        idle;
      logic [4:0]  ran_index;
      logic        finished;
      logic [23:0] completion_time;
      logic [23:0] turnaround_time;
      logic [23:0] waiting_time;
   } rsp_type;

   // One entry of the task table.
   typedef struct packed {
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [7:0]  priority_level;
      logic [15:0] remaining;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan_init;
      logic scan_run;
      logic update;
      logic report;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
   } sts_type;

endpackage

`default_nettype wire

@@ hw/rtl/pss_ctrl.sv @@
// Controller state machine of the preemptive priority scheduler.
`default_nettype none

module pss_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             opcode,
   input  wire pss_pkg::sts_type sts,
   output pss_pkg::cmd_type      cmd,
   output logic                  busy
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_UPDATE = 2'd2;
   localparam logic [1:0] S_REPORT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept && (opcode == pss_pkg::OP_LOAD)) begin
               cmd.load = 1'b1;
            end
            if (accept && (opcode == pss_pkg::OP_TICK)) begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_REPORT;
         end
         S_REPORT: begin
            cmd.report = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // A tick item must make the block busy in the following cycle.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_init |=> busy)
      else $error("tick item accepted but block not busy");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/pss_dp.sv @@
// Datapath of the preemptive priority scheduler: task table, scan and result.
`default_nettype none

module pss_dp #(
   parameter int MAX_TASKS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pss_pkg::cmd_type cmd,
   output pss_pkg::sts_type      sts,
   input  wire pss_pkg::req_type req_item,
   input  wire logic             csr_wr_en,
   input  wire logic [5:0]       csr_wr_data,
   output logic                  rsp_valid,
   output pss_pkg::rsp_type      rsp_item
);

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   // Task table memory and its ports.
   pss_pkg::entry_type entry_mem [MAX_TASKS];
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   pss_pkg::entry_type mem_wdata;
   logic [IDX_W-1:0]   mem_raddr;

   logic [5:0]         num_procs_ff, num_procs_in;
   logic [23:0]        tick_ff, tick_in;
   logic [23:0]        done_ff, done_in;
   logic [MAX_TASKS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   limit_ff, limit_in;
   logic               issued_ff, issued_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               ent_vld_ff, ent_vld_in;
   pss_pkg::entry_type rd_data_ff;
   logic               found_ff, found_in;
   pss_pkg::entry_type best_ff, best_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic               fin_ff, fin_in;
   logic [23:0]        tat_ff, tat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pss_pkg::rsp_type   rsp_ff, rsp_in;

   logic               load_ok;
   logic               issue;
   logic               eligible;
   logic               better;
   logic [23:0]        burst_ext;

   assign load_ok   = (32'(req_item.task_index) < 32'(MAX_TASKS));
   assign issue     = cmd.scan_run && (cnt_ff != limit_ff);
   assign mem_raddr = cnt_ff[IDX_W-1:0];
   assign burst_ext = {8'd0, best_ff.burst};

   // Memory write port: loads, and the remaining-time update of the winner.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = best_idx_ff;
      mem_wdata = best_ff;
      mem_wdata.remaining = best_ff.remaining - 16'd1;
      if (cmd.load && load_ok) begin
         mem_we    = 1'b1;
         mem_waddr = IDX_W'(req_item.task_index);
         mem_wdata.arrival        = req_item.arrival_time;
         mem_wdata.burst          = req_item.burst_length;
         mem_wdata.priority_level = req_item.priority_level;
         mem_wdata.remaining      = req_item.burst_length;
      end else if (cmd.update && found_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[mem_raddr];
   end

   // Eligibility and ordering of the entry whose read data is now present.
   assign eligible = issued_ff && ent_vld_ff && (rd_data_ff.remaining != 16'd0) &&
                     ({8'd0, rd_data_ff.arrival} <= tick_ff);
   assign better   = !found_ff ||
                     (rd_data_ff.priority_level < best_ff.priority_level) ||
                     ((rd_data_ff.priority_level == best_ff.priority_level) &&
                      (rd_data_ff.arrival < best_ff.arrival));

   // Next values of the control and scan registers.
   always_comb begin
      num_procs_in = num_procs_ff;
      tick_in      = tick_ff;
      done_in      = done_ff;
      valid_in     = valid_ff;
      cnt_in       = cnt_ff;
      limit_in     = limit_ff;
      issued_in    = issue;
      rd_idx_in    = mem_raddr;
      ent_vld_in   = valid_ff[mem_raddr];
      found_in     = found_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      fin_in       = fin_ff;
      tat_in       = tat_ff;
      rsp_valid_in = cmd.report;
      rsp_in       = rsp_ff;

      if (csr_wr_en) begin
         num_procs_in = csr_wr_data;
      end

      // A load marks its entry as holding real data.
      if (cmd.load && load_ok) begin
         valid_in[IDX_W'(req_item.task_index)] = 1'b1;
      end

      // Start of a tick: clamp the entry count and fix the finishing time.
      if (cmd.scan_init) begin
         cnt_in   = '0;
         found_in = 1'b0;
         if (32'(num_procs_ff) < 32'(MAX_TASKS)) begin
            limit_in = CNT_W'(num_procs_ff);
         end else begin
            limit_in = CNT_W'(MAX_TASKS);
         end
         done_in = (tick_ff == pss_pkg::TICK_MAX) ? tick_ff : tick_ff + 24'd1;
      end

      if (issue) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end

      // Keep the best eligible entry seen so far.
      if (eligible && better) begin
         found_in    = 1'b1;
         best_in     = rd_data_ff;
         best_idx_in = rd_idx_ff;
      end

      if (cmd.update) begin
         fin_in = found_ff && (best_ff.remaining == 16'd1);
         tat_in = done_ff - {8'd0, best_ff.arrival};
      end

      // Build the result item and advance the clock.
      if (cmd.report) begin
         tick_in                = done_ff;
         rsp_in                 = '0;
         rsp_in.idle            = !found_ff;
         rsp_in.ran_index       = found_ff ? 5'(best_idx_ff) : 5'd0;
         rsp_in.finished        = fin_ff;
         if (fin_ff) begin
            rsp_in.completion_time = done_ff;
            rsp_in.turnaround_time = tat_ff;
            rsp_in.waiting_time    = (tat_ff >= burst_ext) ? tat_ff - burst_ext : 24'd0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_procs_ff <= '0;
         tick_ff      <= '0;
         valid_ff     <= '0;
         issued_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         limit_ff     <= '0;
      end else begin
         num_procs_ff <= num_procs_in;
         tick_ff      <= tick_in;
         valid_ff     <= valid_in;
         issued_ff    <= issued_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         limit_ff     <= limit_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      done_ff     <= done_in;
      rd_idx_ff   <= rd_idx_in;
      ent_vld_ff  <= ent_vld_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      fin_ff      <= fin_in;
      tat_ff      <= tat_in;
      rsp_ff      <= rsp_in;
   end

   assign sts.scan_done = (cnt_ff == limit_ff) && !issued_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_item      = rsp_ff;

`ifndef SYNTHESIS
   // The strobe marks a single cycle.
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   // An idle tick reports nothing else.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.idle) |-> (!rsp_ff.finished && (rsp_ff.ran_index == 5'd0)))
      else $error("idle result carries task data");

   // An update step is always followed by the report step.
   a_report_order: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> cmd.report)
      else $error("update not followed by report");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/preemptive_priority_scheduler_core.sv @@
// Top level of the preemptive priority scheduler: controller plus datapath.
// A load item leaves busy low, so the next item may follow at once.
// A tick item holds busy through the table scan, the update step and the report step;
// the scan reads one table entry per cycle over N = min(num_procs, MAX_TASKS) entries.
// The result strobe rises as busy falls, so the next item may be accepted in its cycle.
// Synchronous reset clears the tick counter, num_procs and the valid flags of all entries.
`default_nettype none

module preemptive_priority_scheduler_core #(
   parameter int MAX_TASKS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire pss_pkg::req_type req_item,
   input  wire logic             csr_wr_en,
   input  wire logic [5:0]       csr_wr_data,
   output logic                  rsp_valid,
   output pss_pkg::rsp_type      rsp_item
);

   pss_pkg::cmd_type cmd;
   pss_pkg::sts_type sts;

   // Sequencing of loads and ticks.
   pss_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_item.opcode),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Task table, winner search and result formation.
   pss_dp #(
      .MAX_TASKS (MAX_TASKS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_item    (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

endmodule

`default_nettype wire

@@ dv/preemptive_priority_scheduler_core_tb.sv @@
// Self-checking testbench of the preemptive priority scheduler core.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_core_tb;

   localparam int NUM_ENTRIES   = 32;
   localparam int SETTLE_CYCLES = 12;
   localparam int QUIET_LIMIT   = 2000;

   // Clock, reset and the block's inputs, all known from time zero.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   pss_pkg::req_type req_item = '0;
   logic csr_wr_en = 1'b0;
   logic [5:0] csr_wr_data = '0;
   logic busy;
   logic rsp_valid;
   pss_pkg::rsp_type rsp_item;

   // Items waiting to be sent and tick reports still to come back.
   pss_pkg::req_type cmd_q[$];
   pss_pkg::rsp_type tick_reports_due[$];

   // Scheduler state as the testbench predicts it.
   logic [15:0] task_arrival[NUM_ENTRIES];
   logic [15:0] task_burst[NUM_ENTRIES];
   logic [7:0]  task_prio[NUM_ENTRIES];
   logic [15:0] task_left[NUM_ENTRIES];
   logic [23:0] tick_count = '0;
   logic [5:0]  sched_count = '0;

   int mismatches = 0;
   int ticks_issued = 0;
   int gap_left = 0;
   int stretch_left = 0;
   bit no_gaps = 1'b0;
   int quiet_cycles = 0;

   always #6 clock = ~clock;

   preemptive_priority_scheduler_core #(
      .MAX_TASKS(NUM_ENTRIES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   // A load overwrites the entry and restarts its remaining time.
   function automatic void load_task(pss_pkg::req_type cmd);
      task_arrival[cmd.task_index] = cmd.arrival_time;
      task_burst[cmd.task_index]   = cmd.burst_length;
      task_prio[cmd.task_index]    = cmd.priority_level;
      task_left[cmd.task_index]    = cmd.burst_length;
   endfunction

   // One tick: pick the winner, serve it once and advance the saturating clock.
   function automatic pss_pkg::rsp_type serve_tick();
      pss_pkg::rsp_type report;
      int unsigned count;
      int unsigned best;
      bit found;
      logic [23:0] done;
      logic [23:0] tat;
      report = '0;
      best = 0;
      found = 1'b0;
      count = (sched_count > NUM_ENTRIES) ? NUM_ENTRIES : sched_count;
      for (int k = 0; k < count; k++) begin
         if (task_arrival[k] > tick_count || task_left[k] == 0) continue;
         if (!found || task_prio[k] < task_prio[best] ||
             (task_prio[k] == task_prio[best] && task_arrival[k] < task_arrival[best])) begin
            best = k;
            found = 1'b1;
         end
      end
      if (!found) begin
         report.idle = 1'b1;
      end else begin
         report.ran_index = best[4:0];
         task_left[best] = task_left[best] - 16'd1;
         if (task_left[best] == 0) begin
            done = (tick_count < pss_pkg::TICK_MAX) ? tick_count + 24'd1 : pss_pkg::TICK_MAX;
            tat = done - 24'(task_arrival[best]);
            report.finished = 1'b1;
            report.completion_time = done;
            report.turnaround_time = tat;
            report.waiting_time = (tat >= 24'(task_burst[best])) ?
                                  tat - 24'(task_burst[best]) : 24'd0;
         end
      end
      if (tick_count < pss_pkg::TICK_MAX) tick_count = tick_count + 24'd1;
      return report;
   endfunction

   function automatic void check_field(string label, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         mismatches++;
      end
   endfunction

   // Driver: present items from the queue, hold while busy, random gaps.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            if (req_item.opcode == pss_pkg::OP_TICK) tick_reports_due.push_back(serve_tick());
            else load_task(req_item);
            // Gaps come in stretches, some of them with no idling at all.
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(8, 40);
               no_gaps = ($urandom_range(0, 3) == 0);
            end
            stretch_left--;
            gap_left = no_gaps ? 0 : $urandom_range(0, 4);
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (cmd_q.size() > 0) begin
               req_item <= cmd_q.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result is checked against the oldest tick report due.
   always @(posedge clock) begin
      pss_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (tick_reports_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_item);
            mismatches++;
         end else begin
            want = tick_reports_due.pop_front();
            check_field("idle", 24'(want.idle), 24'(rsp_item.idle));
            check_field("ran_index", 24'(want.ran_index), 24'(rsp_item.ran_index));
            check_field("finished", 24'(want.finished), 24'(rsp_item.finished));
            check_field("completion_time", want.completion_time, rsp_item.completion_time);
            check_field("turnaround_time", want.turnaround_time, rsp_item.turnaround_time);
            check_field("waiting_time", want.waiting_time, rsp_item.waiting_time);
         end
      end
   end

   // Watchdog: too long without any handshake ends the run.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_wr_en) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic pss_pkg::req_type load_item(int unsigned idx, int unsigned arr,
                                                  int unsigned len, int unsigned prio);
      pss_pkg::req_type cmd;
      cmd.opcode = pss_pkg::OP_LOAD;
      cmd.task_index = idx[4:0];
      cmd.arrival_time = arr[15:0];
      cmd.burst_length = len[15:0];
      cmd.priority_level = prio[7:0];
      return cmd;
   endfunction

   // Loads mostly arrive near the current tick with short bursts and close priorities.
   function automatic pss_pkg::req_type random_load(int unsigned idx);
      int unsigned sel;
      int unsigned arr;
      int unsigned len;
      int unsigned prio;
      sel = $urandom_range(0, 9);
      if (sel < 7) arr = $urandom_range(ticks_issued > 8 ? ticks_issued - 8 : 0, ticks_issued + 8);
      else if (sel == 7) arr = 0;
      else arr = $urandom_range(0, 65535);
      sel = $urandom_range(0, 9);
      if (sel < 7) len = $urandom_range(1, 6);
      else if (sel == 7) len = 0;
      else if (sel == 8) len = $urandom_range(0, 65535);
      else len = $urandom_range(7, 40);
      prio = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3) : $urandom_range(0, 255);
      return load_item(idx, arr, len, prio);
   endfunction

   task automatic push_item(pss_pkg::req_type cmd);
      cmd_q.push_back(cmd);
      if (cmd.opcode == pss_pkg::OP_TICK) ticks_issued++;
   endtask

   // Tick items carry random content in the fields that they do not use.
   task automatic push_tick();
      pss_pkg::req_type cmd;
      logic [63:0] noise;
      noise = {$urandom(), $urandom()};
      cmd = noise[$bits(pss_pkg::req_type)-1:0];
      cmd.opcode = pss_pkg::OP_TICK;
      push_item(cmd);
   endtask

   task automatic queue_random(int n);
      int unsigned active;
      active = (sched_count > NUM_ENTRIES) ? NUM_ENTRIES : sched_count;
      repeat (n) begin
         if ($urandom_range(0, 99) < 55) push_tick();
         else if (active > 0 && $urandom_range(0, 9) < 8)
            push_item(random_load($urandom_range(0, active - 1)));
         else
            push_item(random_load($urandom_range(0, NUM_ENTRIES - 1)));
      end
   endtask

   // Wait until every item is taken and every report is in, then let the block settle.
   task automatic wait_drained();
      do @(negedge clock); while (cmd_q.size() != 0 || start || tick_reports_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_num_procs(logic [5:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sched_count = value;
      @(negedge clock);
   endtask

   // Stimulus phases.
   initial begin
      int base;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Fill every entry while no entry is considered; ticks report idle.
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         push_item(random_load(k));
         if (k % 8 == 0) push_tick();
      end
      wait_drained();

      // Directed part over four entries.
      write_num_procs(6'd4);
      base = ticks_issued;
      push_item(load_item(0, 0, 1, 0));
      push_item(load_item(1, 16'hFFFF, 16'hFFFF, 8'hFF));   // never arrives
      push_item(load_item(2, 0, 0, 0));                     // zero burst
      push_item(load_item(3, 0, 2, 200));
      push_tick();                                          // entry 0 runs and finishes
      push_tick();
      push_item(load_item(3, 0, 3, 200));                   // reload restarts the burst
      push_tick();
      // Equal priority: the earlier arrival wins, then the lower index.
      push_item(load_item(0, base + 1, 2, 9));
      push_item(load_item(2, base, 1, 9));
      push_tick();
      push_item(load_item(2, base + 1, 1, 9));
      push_tick();
      push_tick();
      push_tick();
      push_tick();
      push_tick();
      push_tick();                                          // nothing eligible
      wait_drained();

      // Random phases over several settings, the extremes among them.
      write_num_procs(6'd32);
      queue_random(200);
      wait_drained();
      write_num_procs(6'd1);
      queue_random(100);
      wait_drained();
      write_num_procs(6'd63);
      queue_random(150);
      wait_drained();
      write_num_procs(6'd0);
      queue_random(30);
      wait_drained();
      write_num_procs(6'd17);
      queue_random(150);
      wait_drained();
      write_num_procs(6'd40);
      queue_random(120);
      wait_drained();
      write_num_procs(6'd32);
      queue_random(200);
      wait_drained();

      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
